### rtl/assert_macros.svh
// Assertion helpers used by the checker file dfdg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dfdg_pkg.sv
package dfdg_pkg;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 60;
    localparam int DIGITS_W   = 6;
    localparam int PC_W       = 3;

    localparam logic [DIGITS_W-1:0] DIGITS_RESET     = 6'd10;
    localparam logic [DIGITS_W-1:0] INT_STEPS_LAST   = 6'd63;
    localparam logic [DIGITS_W-1:0] DIGIT_STEPS_LAST = 6'd3;

    localparam logic PART_INT  = 1'b0;
    localparam logic PART_FRAC = 1'b1;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } operands_t;

    typedef struct packed {
        logic                  part;
        logic [DIVIDEND_W-1:0] value;
        logic                  last;
    } result_t;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_STEP,
        OP_EMIT_INT,
        OP_LOAD_DIG,
        OP_EMIT_DIG,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOSTART,
        C_CNT_NZ,
        C_LAST,
        C_NOT_LAST
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic accept;
    } dp_ctrl_t;

    typedef struct packed {
        logic cnt_nz;
        logic zero_div;
    } dp_status_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            3'd0:    w = '{op: OP_ACCEPT,   cond: C_NOSTART,  target: 3'd0};
            3'd1:    w = '{op: OP_STEP,     cond: C_CNT_NZ,   target: 3'd1};
            3'd2:    w = '{op: OP_EMIT_INT, cond: C_LAST,     target: 3'd0};
            3'd3:    w = '{op: OP_LOAD_DIG, cond: C_NEVER,    target: 3'd0};
            3'd4:    w = '{op: OP_STEP,     cond: C_CNT_NZ,   target: 3'd4};
            3'd5:    w = '{op: OP_EMIT_DIG, cond: C_NOT_LAST, target: 3'd3};
            3'd6:    w = '{op: OP_NOP,      cond: C_ALWAYS,   target: 3'd0};
            default: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: 3'd0};
        endcase
        return w;
    endfunction

endpackage

### rtl/dfdg_datapath.sv
module dfdg_datapath
    import dfdg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_ctrl_t              ctrl,
    input  operands_t             operands,
    output logic [DIVIDEND_W-1:0] quot,
    output dp_status_t            status
);

    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVISOR_W-1:0]  r_reg, r_next;
    logic [DIVISOR_W-1:0]  d_reg, d_next;
    logic                  zf_reg, zf_next;
    logic [DIGITS_W-1:0]   cnt_reg, cnt_next;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W+1:0]  diff;
    logic                  ge;
    logic [DIVIDEND_W-1:0] times_ten;

    always_comb
    begin
        rem_sh    = {r_reg, q_reg[DIVIDEND_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, d_reg};
        ge        = ~diff[DIVISOR_W+1];
        times_ten = ({4'b0000, r_reg} << 3) + ({4'b0000, r_reg} << 1);
    end

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        zf_next  = zf_reg;
        cnt_next = cnt_reg;
        unique case (ctrl.op)
            OP_ACCEPT:
            begin
                if (ctrl.accept)
                begin
                    q_next   = operands.dividend;
                    r_next   = '0;
                    d_next   = operands.divisor;
                    zf_next  = (operands.divisor == '0);
                    cnt_next = INT_STEPS_LAST;
                end
            end
            OP_STEP:
            begin
                q_next   = {q_reg[DIVIDEND_W-2:0], ge | zf_reg};
                if (zf_reg)
                    r_next = '0;
                else if (ge)
                    r_next = diff[DIVISOR_W-1:0];
                else
                    r_next = rem_sh[DIVISOR_W-1:0];
                cnt_next = cnt_reg - 1'b1;
            end
            OP_LOAD_DIG:
            begin
                r_next   = times_ten[DIVIDEND_W-1:4];
                q_next   = {times_ten[3:0], {DIVISOR_W{1'b0}}};
                cnt_next = DIGIT_STEPS_LAST;
            end
            OP_EMIT_INT, OP_EMIT_DIG, OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zf_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            zf_reg  <= zf_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quot            = q_reg;
    assign status.cnt_nz   = (cnt_reg != '0);
    assign status.zero_div = zf_reg;

endmodule

### rtl/decimal_fraction_digit_generator.sv
// The integer quotient is emitted, registered, once the radix-2 restoring divider,
// retiring one quotient bit per cycle, has stepped through all 64 dividend bits.
// Each fractional digit then takes a times-ten load, 4 divider steps and one emit.
// An item keeps busy high through all these steps, plus a closing idle step if digits follow.
// Reset clears the sequencer to idle and sets fraction_digits to 10; results are not stalled.
module decimal_fraction_digit_generator
    import dfdg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [DIGITS_W-1:0] cfg_data,
    input  logic                start,
    input  operands_t           operands,
    output logic                busy,
    output logic                result_valid,
    output result_t             result
);

    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [DIGITS_W-1:0] frac_digits_reg;
    logic [DIGITS_W-1:0] n_reg, n_next;
    logic [DIGITS_W-1:0] k_reg, k_next;
    logic                result_valid_reg, result_valid_next;
    result_t             result_reg, result_next;

    ucode_t                uw;
    dp_ctrl_t              dp_ctrl;
    dp_status_t            dp_status;
    logic [DIVIDEND_W-1:0] quot;
    logic                  accept;
    logic                  last_now;
    logic                  jump;

    assign uw     = ucode_rom(pc_reg);
    assign busy   = (pc_reg != '0);
    assign accept = start && !busy;

    dfdg_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (dp_ctrl),
        .operands (operands),
        .quot     (quot),
        .status   (dp_status)
    );

    always_comb
    begin
        if (uw.op == OP_EMIT_INT)
            last_now = (n_reg == '0);
        else
            last_now = ((k_reg + 1'b1) == n_reg);
    end

    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NOSTART:  jump = !start;
            C_CNT_NZ:   jump = dp_status.cnt_nz;
            C_LAST:     jump = last_now;
            C_NOT_LAST: jump = !last_now;
            default:    jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + 1'b1;
    end

    always_comb
    begin
        dp_ctrl.op        = uw.op;
        dp_ctrl.accept    = accept;
        n_next            = n_reg;
        k_next            = k_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        unique case (uw.op)
            OP_ACCEPT:
            begin
                if (accept)
                begin
                    n_next = frac_digits_reg;
                    k_next = '0;
                end
            end
            OP_EMIT_INT:
            begin
                result_valid_next = 1'b1;
                result_next.part  = PART_INT;
                result_next.value = quot;
                result_next.last  = last_now;
            end
            OP_EMIT_DIG:
            begin
                result_valid_next = 1'b1;
                result_next.part  = PART_FRAC;
                result_next.value = dp_status.zero_div ? '0
                                    : {{(DIVIDEND_W-4){1'b0}}, quot[3:0]};
                result_next.last  = last_now;
                k_next            = k_reg + 1'b1;
            end
            OP_STEP, OP_LOAD_DIG, OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= '0;
            frac_digits_reg  <= DIGITS_RESET;
            n_reg            <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg           <= pc_next;
            n_reg            <= n_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
                frac_digits_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/dfdg_checker.sv
`include "assert_macros.svh"

module dfdg_checker
    import dfdg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_we,
    input logic [DIGITS_W-1:0] cfg_data,
    input logic                start,
    input operands_t           operands,
    input logic                busy,
    input logic                result_valid,
    input result_t             result
);

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not raise busy")
    `ASSERT_SAME(a_rose_start, clk, rst_n, $rose(busy), $past(start), "busy rose without start")
    `ASSERT_SAME(a_more_busy, clk, rst_n, result_valid && !result.last, busy, "item ended before last")
    `ASSERT_SAME(a_digit_range, clk, rst_n, result_valid && result.part, result.value < 64'd10,
                 "fractional digit out of range")
    `ASSERT_NEXT(a_strobe_once, clk, rst_n, result_valid && result.part == PART_INT,
                 !(result_valid && result.part == PART_INT), "integer result repeated")

endmodule

bind decimal_fraction_digit_generator dfdg_checker u_dfdg_checker (.*);

### sim/decimal_fraction_digit_generator_checker.sv
`timescale 1ns / 100ps

module decimal_fraction_digit_generator_checker
    import dfdg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [DIGITS_W-1:0] cfg_data,
    input  logic                start,
    input  operands_t           operands,
    input  logic                busy,
    input  logic                result_valid,
    input  result_t             result,
    output int                  mismatch_count,
    output int                  pending_results,
    output int                  items_taken,
    output int                  results_checked
);

    logic [DIGITS_W-1:0] digit_setting;
    result_t             expansion_q[$];
    int                  fails;
    int                  n_items;
    int                  n_results;

    task automatic predict_expansion(input operands_t op);
        logic [DIVIDEND_W-1:0] a;
        logic [DIVIDEND_W-1:0] quot;
        logic [DIVIDEND_W-1:0] t;
        logic [DIVIDEND_W-1:0] digit;
        logic [DIVISOR_W-1:0]  b;
        logic [DIVISOR_W-1:0]  rem;
        result_t               r;
        a = op.dividend;
        b = op.divisor;
        if (b == '0)
        begin
            quot = '1;
            rem  = '0;
        end
        else
        begin
            quot = a / b;
            t    = a % b;
            rem  = t[DIVISOR_W-1:0];
        end
        r.part  = PART_INT;
        r.value = quot;
        r.last  = (digit_setting == '0);
        expansion_q = {expansion_q, r};
        for (int k = 1; k <= digit_setting; k++)
        begin
            digit = '0;
            if (b != '0)
            begin
                t     = {4'b0, rem} * 64'd10;
                digit = t / b;
                t     = t - digit * b;
                rem   = t[DIVISOR_W-1:0];
            end
            r.part  = PART_FRAC;
            r.value = digit;
            r.last  = (k == digit_setting);
            expansion_q = {expansion_q, r};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            digit_setting   <= DIGITS_RESET;
            fails = 0;
            n_items = 0;
            n_results = 0;
            expansion_q.delete();
            mismatch_count  <= 0;
            pending_results <= 0;
            items_taken     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                n_results++;
                if (expansion_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: extra result, expected none, actual part %0d value %0d last %0d",
                             $time, result.part, result.value, result.last);
                end
                else
                begin
                    exp_r = expansion_q.pop_front();
                    if (result.part !== exp_r.part)
                    begin
                        fails++;
                        $display("%0t: part mismatch, expected %0d, actual %0d",
                                 $time, exp_r.part, result.part);
                    end
                    if (result.value !== exp_r.value)
                    begin
                        fails++;
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, exp_r.value, result.value);
                    end
                    if (result.last !== exp_r.last)
                    begin
                        fails++;
                        $display("%0t: last mismatch, expected %0d, actual %0d",
                                 $time, exp_r.last, result.last);
                    end
                end
            end
            if (start && !busy)
            begin
                n_items++;
                predict_expansion(operands);
            end
            if (cfg_we)
                digit_setting <= cfg_data;
            mismatch_count  <= fails;
            pending_results <= expansion_q.size();
            items_taken     <= n_items;
            results_checked <= n_results;
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dfdg_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_ITEMS  = 30;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_we       = 1'b0;
    logic [DIGITS_W-1:0] cfg_data     = '0;
    logic                start        = 1'b0;
    operands_t           operands     = '0;
    logic                busy;
    logic                result_valid;
    result_t             result;

    int mismatch_count;
    int pending_results;
    int items_taken;
    int results_checked;
    int idle_cycles = 0;
    int settings_used = 1;
    bit quiet_sender = 1'b0;

    always #5 clk = ~clk;

    decimal_fraction_digit_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .start        (start),
        .operands     (operands),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    decimal_fraction_digit_generator_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .start           (start),
        .operands        (operands),
        .busy            (busy),
        .result_valid    (result_valid),
        .result          (result),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .items_taken     (items_taken),
        .results_checked (results_checked)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item or result moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [DIVIDEND_W-1:0] a, input logic [DIVISOR_W-1:0] b);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start             <= 1'b1;
        operands.dividend <= a;
        operands.divisor  <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0 || busy);
    endtask

    task automatic write_digits(input logic [DIGITS_W-1:0] n);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_item();
        logic [DIVIDEND_W-1:0] a;
        logic [DIVISOR_W-1:0]  b;
        a = {$urandom, $urandom};
        b = DIVISOR_W'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0: b = DIVISOR_W'($urandom_range(1, 12));
            1: b = b >> $urandom_range(0, 59);
            2: b = 60'd1 << $urandom_range(0, 59);
            3: b = '1;
            default: ;
        endcase
        if (b == '0)
            b = 60'd1;
        if ($urandom_range(0, 49) == 0)
            b = '0;
        case ($urandom_range(0, 9))
            0: a = DIVIDEND_W'($urandom_range(0, 99));
            1: a = (b == '0) ? a : a % b;
            2: a = {4'b0000, b} * DIVIDEND_W'($urandom_range(0, 15));
            3: a = '1;
            4: a = a >> $urandom_range(0, 63);
            default: ;
        endcase
        send_item(a, b);
    endtask

    initial
    begin
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting of ten digits.
        send_item(64'd0, 60'd1);
        send_item('1, 60'd1);
        send_item('1, '1);
        send_item(64'd1, 60'd3);
        send_item(64'd22, 60'd7);
        send_item(64'd5, 60'd8);
        send_item(64'd7, 60'd7);
        send_item(64'd12345, '0);
        send_item(64'h8000_0000_0000_0000, 60'h800_0000_0000_0000);
        send_item('1, 60'h0FF_FFFF_FFFF_FFFF);

        write_digits(6'd0);
        send_item(64'd0, 60'd1);
        send_item('1, '1);
        send_item(64'd100, 60'd9);
        send_item('1, '0);

        write_digits(6'd63);
        send_item(64'd1, 60'd7);
        send_item('1, 60'hFFF_FFFF_FFFF_FFFE);
        send_item(64'd3, '0);

        write_digits(6'd1);
        send_item(64'd19, 60'd20);
        send_item(64'd1, 60'd1);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: n = 63;
                1: n = 0;
                2: n = $urandom_range(0, 63);
                default: n = $urandom_range(0, 12);
            endcase
            write_digits(DIGITS_W'(n));
            quiet_sender = (p % 4 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p % 2 == 1 && i == PHASE_ITEMS / 2)
                    drain_results();
                send_random_item();
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("Checked %0d results from %0d items over %0d digit settings,",
                 results_checked, items_taken, settings_used);
        $display("including 0 and 63 digits, zero divisors and extreme operands.");
        if (mismatch_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/dfdg_pkg.sv
rtl/dfdg_datapath.sv
rtl/decimal_fraction_digit_generator.sv
rtl/dfdg_checker.sv
sim/decimal_fraction_digit_generator_checker.sv
sim/testbench.sv
